// ===== sv/i2crts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crts_pkg
// Shared types and codes for the I2C register transaction sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2crts_pkg;

	// input operation codes
	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_WRBYTE = 3'd1,
		OP_MDONE  = 3'd2,
		OP_SBYTE  = 3'd3,
		OP_TICK   = 3'd4
	} op_t;

	// engine actions
	typedef enum logic [2:0] {
		ACT_ADDR     = 3'd0,
		ACT_SEND     = 3'd1,
		ACT_REQ      = 3'd2,
		ACT_DELIVER  = 3'd3,
		ACT_STOP     = 3'd4,
		ACT_FINISH   = 3'd5,
		ACT_READNEXT = 3'd6
	} action_t;

	// completion status
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_NODEV  = 3'd1,
		ST_NOACK  = 3'd2,
		ST_BUSERR = 3'd3,
		ST_BADLEN = 3'd4
	} status_t;

	// sequencer phase
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_MB_ADDR   = 4'd1,
		PH_MB_REGHI  = 4'd2,
		PH_MB_REGLO  = 4'd3,
		PH_NEED_BYTE = 4'd4,
		PH_MB_DATA   = 4'd5,
		PH_SB_WAIT   = 4'd6
	} phase_t;

	localparam logic [15:0] WAIT_RESET = 16'd2000;
	localparam logic [7:0]  READ_BIT   = 8'h01;
	localparam logic [1:0]  REG_MAX    = 2'd2;
	localparam logic [1:0]  REG_ALL    = 2'd3;
	localparam int          MAX_RES    = 3;

	// one input item
	typedef struct packed {
		logic [2:0]  op;
		logic        is_read;
		logic [7:0]  device_byte;
		logic [1:0]  reg_bytes;
		logic [15:0] reg_addr;
		logic [15:0] length;
		logic [7:0]  write_byte;
		logic        rx_nack;
		logic        arb_lost;
		logic        bus_fault;
		logic [7:0]  rx_byte;
	} item_t;

	// one result item
	typedef struct packed {
		action_t    action;
		logic [7:0] byte_value;
		logic       nack_next;
		status_t    status;
		logic       last;
	} result_t;

	// transaction context held between items
	typedef struct packed {
		phase_t      phase;
		logic [15:0] reg_addr;
		logic [7:0]  device;
		logic        is_read;
		logic [1:0]  reg_bytes;
		status_t     pending;
		logic [15:0] wait_count;
	} hold_t;

	// build a result with last cleared
	function automatic result_t mk_res(action_t a, logic [7:0] v, logic n, status_t s);
		result_t r;
		r.action     = a;
		r.byte_value = v;
		r.nack_next  = n;
		r.status     = s;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/i2crts_step.sv =====
// ----------------------------------------------------------------------------
// i2crts_step
// Next-context and result logic for one item against the held context.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crts_step #(
	parameter int COUNT_BITS = 16
) (
	input  wire i2crts_pkg::item_t              item,
	input  wire i2crts_pkg::hold_t              hold,
	input  wire logic [COUNT_BITS-1:0]          rem,
	input  wire logic [15:0]                    wait_limit,
	output i2crts_pkg::hold_t                   hold_nxt,
	output logic [COUNT_BITS-1:0]               rem_nxt,
	output i2crts_pkg::result_t [2:0]           res,
	output logic [1:0]                          res_cnt
);

	localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

	logic [1:0]            rb;
	logic [COUNT_BITS-1:0] len_c;
	logic [COUNT_BITS-1:0] rem_dec;
	logic [15:0]           wc_dec;
	logic                  mb_wait;

	assign rb      = (item.reg_bytes == i2crts_pkg::REG_ALL) ? i2crts_pkg::REG_MAX
	                                                         : item.reg_bytes;
	assign len_c   = item.length[COUNT_BITS-1:0];
	assign rem_dec = rem - ONE;
	assign wc_dec  = hold.wait_count - 16'd1;
	assign mb_wait = (hold.phase == i2crts_pkg::PH_MB_ADDR)  ||
	                 (hold.phase == i2crts_pkg::PH_MB_REGHI) ||
	                 (hold.phase == i2crts_pkg::PH_MB_REGLO) ||
	                 (hold.phase == i2crts_pkg::PH_MB_DATA);

	// sequence step
	always_comb begin
		hold_nxt = hold;
		rem_nxt  = rem;
		res_cnt  = 2'd0;
		for (int i = 0; i < i2crts_pkg::MAX_RES; i++) begin
			res[i] = i2crts_pkg::mk_res(i2crts_pkg::ACT_ADDR, 8'h00, 1'b0, i2crts_pkg::ST_OK);
		end
		case (item.op)
			i2crts_pkg::OP_START: begin
				if (hold.phase == i2crts_pkg::PH_IDLE) begin
					hold_nxt.is_read   = item.is_read;
					hold_nxt.device    = item.device_byte;
					hold_nxt.reg_bytes = rb;
					hold_nxt.reg_addr  = item.reg_addr;
					rem_nxt            = len_c;
					res_cnt            = 2'd1;
					if (item.is_read && len_c == '0) begin
						res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_FINISH, 8'h00, 1'b0,
							i2crts_pkg::ST_BADLEN);
					end else if (item.is_read && rb == 2'd0) begin
						res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_ADDR,
							item.device_byte | i2crts_pkg::READ_BIT, len_c == ONE,
							i2crts_pkg::ST_OK);
						hold_nxt.pending    = i2crts_pkg::ST_NOACK;
						hold_nxt.phase      = i2crts_pkg::PH_SB_WAIT;
						hold_nxt.wait_count = wait_limit;
					end else begin
						res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_ADDR, item.device_byte,
							1'b0, i2crts_pkg::ST_OK);
						hold_nxt.pending    = i2crts_pkg::ST_NODEV;
						hold_nxt.phase      = i2crts_pkg::PH_MB_ADDR;
						hold_nxt.wait_count = wait_limit;
					end
				end
			end
			i2crts_pkg::OP_WRBYTE: begin
				if (hold.phase == i2crts_pkg::PH_NEED_BYTE) begin
					res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_SEND, item.write_byte, 1'b0,
						i2crts_pkg::ST_OK);
					res_cnt             = 2'd1;
					rem_nxt             = rem_dec;
					hold_nxt.phase      = i2crts_pkg::PH_MB_DATA;
					hold_nxt.wait_count = wait_limit;
				end
			end
			i2crts_pkg::OP_MDONE: begin
				if (mb_wait) begin
					if (item.bus_fault || item.rx_nack || item.arb_lost) begin
						// failure: stop then finish
						res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_STOP, 8'h00, 1'b0,
							i2crts_pkg::ST_OK);
						res[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_FINISH, 8'h00, 1'b0,
							(!item.bus_fault && item.rx_nack) ? hold.pending
							                                  : i2crts_pkg::ST_BUSERR);
						res_cnt        = 2'd2;
						hold_nxt.phase = i2crts_pkg::PH_IDLE;
					end else begin
						hold_nxt.pending = i2crts_pkg::ST_NOACK;
						res_cnt          = 2'd1;
						if (hold.phase == i2crts_pkg::PH_MB_ADDR && hold.reg_bytes >= 2'd2) begin
							res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_SEND,
								hold.reg_addr[15:8], 1'b0, i2crts_pkg::ST_OK);
							hold_nxt.phase      = i2crts_pkg::PH_MB_REGHI;
							hold_nxt.wait_count = wait_limit;
						end else if ((hold.phase == i2crts_pkg::PH_MB_ADDR &&
						              hold.reg_bytes == 2'd1) ||
						             hold.phase == i2crts_pkg::PH_MB_REGHI) begin
							res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_SEND,
								hold.reg_addr[7:0], 1'b0, i2crts_pkg::ST_OK);
							hold_nxt.phase      = i2crts_pkg::PH_MB_REGLO;
							hold_nxt.wait_count = wait_limit;
						end else if (hold.phase == i2crts_pkg::PH_MB_REGLO && hold.is_read) begin
							// repeated start in the read direction
							res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_ADDR,
								hold.device | i2crts_pkg::READ_BIT, rem == ONE,
								i2crts_pkg::ST_OK);
							hold_nxt.phase      = i2crts_pkg::PH_SB_WAIT;
							hold_nxt.wait_count = wait_limit;
						end else if (rem != '0) begin
							res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_REQ, 8'h00, 1'b0,
								i2crts_pkg::ST_OK);
							hold_nxt.phase = i2crts_pkg::PH_NEED_BYTE;
						end else begin
							res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_STOP, 8'h00, 1'b0,
								i2crts_pkg::ST_OK);
							res[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_FINISH, 8'h00, 1'b0,
								i2crts_pkg::ST_OK);
							res_cnt        = 2'd2;
							hold_nxt.phase = i2crts_pkg::PH_IDLE;
						end
					end
				end
			end
			i2crts_pkg::OP_SBYTE: begin
				if (hold.phase == i2crts_pkg::PH_SB_WAIT) begin
					if (item.rx_nack || item.arb_lost) begin
						res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_STOP, 8'h00, 1'b0,
							i2crts_pkg::ST_OK);
						res[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_FINISH, 8'h00, 1'b0,
							item.rx_nack ? i2crts_pkg::ST_NOACK : i2crts_pkg::ST_BUSERR);
						res_cnt        = 2'd2;
						hold_nxt.phase = i2crts_pkg::PH_IDLE;
					end else begin
						res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_DELIVER, item.rx_byte, 1'b0,
							i2crts_pkg::ST_OK);
						rem_nxt = rem_dec;
						if (rem_dec == '0) begin
							res[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_STOP, 8'h00, 1'b0,
								i2crts_pkg::ST_OK);
							res[2] = i2crts_pkg::mk_res(i2crts_pkg::ACT_FINISH, 8'h00, 1'b0,
								i2crts_pkg::ST_OK);
							res_cnt        = 2'd3;
							hold_nxt.phase = i2crts_pkg::PH_IDLE;
						end else begin
							res[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_READNEXT, 8'h00,
								rem_dec == ONE, i2crts_pkg::ST_OK);
							res_cnt             = 2'd2;
							hold_nxt.wait_count = wait_limit;
						end
					end
				end
			end
			i2crts_pkg::OP_TICK: begin
				if (hold.phase != i2crts_pkg::PH_IDLE &&
				    hold.phase != i2crts_pkg::PH_NEED_BYTE) begin
					hold_nxt.wait_count = wc_dec;
					if (wc_dec == 16'd0) begin
						// wait timeout
						res[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_STOP, 8'h00, 1'b0,
							i2crts_pkg::ST_OK);
						res[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_FINISH, 8'h00, 1'b0,
							i2crts_pkg::ST_BUSERR);
						res_cnt        = 2'd2;
						hold_nxt.phase = i2crts_pkg::PH_IDLE;
					end
				end
			end
			default: begin
				res_cnt = 2'd0;
			end
		endcase
		// mark the final result of this item
		case (res_cnt)
			2'd1:    res[0].last = 1'b1;
			2'd2:    res[1].last = 1'b1;
			2'd3:    res[2].last = 1'b1;
			default: res[0].last = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/i2crts_outbuf.sv =====
// ----------------------------------------------------------------------------
// i2crts_outbuf
// Result register holding up to three results, drained one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crts_outbuf (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire i2crts_pkg::result_t [2:0]     res,
	input  wire logic [1:0]                    res_cnt,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output i2crts_pkg::result_t                out_res,
	output logic                               free
);

	i2crts_pkg::result_t [2:0] buf_q;
	logic [1:0]                cnt_q;
	logic [1:0]                idx_q;
	logic                      take;

	assign out_valid = (cnt_q != 2'd0);
	assign take      = out_valid && out_ready;
	assign free      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);

	// select the current entry
	always_comb begin
		case (idx_q)
			2'd0:    out_res = buf_q[0];
			2'd1:    out_res = buf_q[1];
			2'd2:    out_res = buf_q[2];
			default: out_res = buf_q[0];
		endcase
	end

	// fill and drain control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res_cnt;
			idx_q <= 2'd0;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== sv/i2c_register_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer
// Runs I2C register read and write transactions above a byte-level engine.
// ----------------------------------------------------------------------------
//
// channel   handshake                  payload
// input     in_valid / in_ready        op, is_read, device_byte, reg_bytes, reg_addr,
//                                      length, write_byte, rx_nack, arb_lost,
//                                      bus_fault, rx_byte
// output    out_valid / out_ready      action, byte_value, nack_next, status, last
// config    wait_limit_we              wait_limit_wdata
//
// An item is registered on transfer and evaluated from the input register, loading
// up to three results into the result register once that register is free.
// One item per cycle is accepted while each item gives at most one result;
// an item with more results stalls the input until all but its last result are
// taken, and any output stall adds to that.
// Reset clears the context and sets wait_limit to 2000.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_transaction_sequencer #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wait_limit_we,
	input  wire logic [15:0] wait_limit_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  op,
	input  wire logic        is_read,
	input  wire logic [7:0]  device_byte,
	input  wire logic [1:0]  reg_bytes,
	input  wire logic [15:0] reg_addr,
	input  wire logic [15:0] length,
	input  wire logic [7:0]  write_byte,
	input  wire logic        rx_nack,
	input  wire logic        arb_lost,
	input  wire logic        bus_fault,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       action,
	output logic [7:0]       byte_value,
	output logic             nack_next,
	output logic [2:0]       status,
	output logic             last
);

	logic [15:0]               wait_limit_q;
	i2crts_pkg::item_t         item_s1;
	logic                      valid_s1;
	i2crts_pkg::hold_t         hold_q;
	logic [COUNT_BITS-1:0]     rem_q;
	i2crts_pkg::hold_t         hold_nxt;
	logic [COUNT_BITS-1:0]     rem_nxt;
	i2crts_pkg::result_t [2:0] res;
	logic [1:0]                res_cnt;
	i2crts_pkg::result_t       out_res;
	logic                      buf_free;
	logic                      advance;

	assign advance  = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || buf_free;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_limit_q <= i2crts_pkg::WAIT_RESET;
		end else if (wait_limit_we) begin
			wait_limit_q <= wait_limit_wdata;
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op          <= op;
			item_s1.is_read     <= is_read;
			item_s1.device_byte <= device_byte;
			item_s1.reg_bytes   <= reg_bytes;
			item_s1.reg_addr    <= reg_addr;
			item_s1.length      <= length;
			item_s1.write_byte  <= write_byte;
			item_s1.rx_nack     <= rx_nack;
			item_s1.arb_lost    <= arb_lost;
			item_s1.bus_fault   <= bus_fault;
			item_s1.rx_byte     <= rx_byte;
		end
	end

	// transaction context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q.phase      <= i2crts_pkg::PH_IDLE;
			hold_q.reg_addr   <= 16'd0;
			hold_q.device     <= 8'd0;
			hold_q.is_read    <= 1'b0;
			hold_q.reg_bytes  <= 2'd0;
			hold_q.pending    <= i2crts_pkg::ST_OK;
			hold_q.wait_count <= 16'd0;
			rem_q             <= '0;
		end else if (advance) begin
			hold_q <= hold_nxt;
			rem_q  <= rem_nxt;
		end
	end

	i2crts_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.item       (item_s1),
		.hold       (hold_q),
		.rem        (rem_q),
		.wait_limit (wait_limit_q),
		.hold_nxt   (hold_nxt),
		.rem_nxt    (rem_nxt),
		.res        (res),
		.res_cnt    (res_cnt)
	);

	i2crts_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.res_cnt   (res_cnt),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_res   (out_res),
		.free      (buf_free)
	);

	// result fields
	assign action     = out_res.action;
	assign byte_value = out_res.byte_value;
	assign nack_next  = out_res.nack_next;
	assign status     = out_res.status;
	assign last       = out_res.last;

endmodule

`default_nettype wire

// ===== dv/tb_i2c_register_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_register_transaction_sequencer
// Self-checking bench for the I2C register transaction sequencer. A behavioral
// mirror of the sequencer predicts the engine actions for every input transfer.
// Directed tests cover the write and read flows, engine failures, wait
// timeouts and dropped items. Random traffic then follows the predicted phase
// under several wait limits. Both channels idle at random, and one long
// output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_i2c_register_transaction_sequencer;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int         RUN_LIMIT = 10000000;

	// clock, reset and ports
	logic        clk = 1'b0;
	logic        arst_n;
	logic        wait_limit_we;
	logic [15:0] wait_limit_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  op;
	logic        is_read;
	logic [7:0]  device_byte;
	logic [1:0]  reg_bytes;
	logic [15:0] reg_addr;
	logic [15:0] length;
	logic [7:0]  write_byte;
	logic        rx_nack;
	logic        arb_lost;
	logic        bus_fault;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  action;
	logic [7:0]  byte_value;
	logic        nack_next;
	logic [2:0]  status;
	logic        last;

	int errors = 0;

	// mirror of the sequencer context
	i2crts_pkg::phase_t  seq_phase;
	logic [15:0]         bytes_left;
	logic [15:0]         hold_addr;
	logic [7:0]          hold_dev;
	logic                hold_read;
	logic [1:0]          hold_nreg;
	i2crts_pkg::status_t fail_code;
	logic [15:0]         wait_left;
	logic [15:0]         limit_mirror;

	// engine actions predicted for one transfer, then queued in order
	i2crts_pkg::result_t step_res [0:i2crts_pkg::MAX_RES-1];
	int                  step_n;
	i2crts_pkg::result_t action_queue [$];

	// sender and receiver pacing
	int burst_left = 0;
	int holdoff_request = 0;
	int hold_left = 0;
	int rx_run = 0;
	int rx_mode = 0;
	int rx_tick = 0;

	always #10 clk = ~clk;

	i2c_register_transaction_sequencer uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.wait_limit_we    (wait_limit_we),
		.wait_limit_wdata (wait_limit_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.is_read          (is_read),
		.device_byte      (device_byte),
		.reg_bytes        (reg_bytes),
		.reg_addr         (reg_addr),
		.length           (length),
		.write_byte       (write_byte),
		.rx_nack          (rx_nack),
		.arb_lost         (arb_lost),
		.bus_fault        (bus_fault),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.action           (action),
		.byte_value       (byte_value),
		.nack_next        (nack_next),
		.status           (status),
		.last             (last)
	);

	// ------------------------------------------------------------------
	// sequencer mirror
	// ------------------------------------------------------------------
	function automatic void clear_mirror();
		seq_phase    = i2crts_pkg::PH_IDLE;
		bytes_left   = 16'd0;
		hold_addr    = 16'd0;
		hold_dev     = 8'd0;
		hold_read    = 1'b0;
		hold_nreg    = 2'd0;
		fail_code    = i2crts_pkg::ST_OK;
		wait_left    = 16'd0;
		limit_mirror = i2crts_pkg::WAIT_RESET;
	endfunction

	function automatic void emit(i2crts_pkg::action_t a, logic [7:0] v, logic n,
	                             i2crts_pkg::status_t s);
		i2crts_pkg::result_t r;
		r.action     = a;
		r.byte_value = v;
		r.nack_next  = n;
		r.status     = s;
		r.last       = 1'b0;
		step_res[step_n] = r;
		step_n++;
	endfunction

	function automatic void open_wait(i2crts_pkg::phase_t p);
		seq_phase = p;
		wait_left = limit_mirror;
	endfunction

	function automatic void close_out(i2crts_pkg::status_t s);
		emit(i2crts_pkg::ACT_STOP, 8'h00, 1'b0, i2crts_pkg::ST_OK);
		emit(i2crts_pkg::ACT_FINISH, 8'h00, 1'b0, s);
		seq_phase = i2crts_pkg::PH_IDLE;
	endfunction

	function automatic void issue_read_address();
		emit(i2crts_pkg::ACT_ADDR, hold_dev | i2crts_pkg::READ_BIT, bytes_left == 16'd1,
			i2crts_pkg::ST_OK);
		fail_code = i2crts_pkg::ST_NOACK;
		open_wait(i2crts_pkg::PH_SB_WAIT);
	endfunction

	function automatic void data_or_stop();
		if (bytes_left != 16'd0) begin
			seq_phase = i2crts_pkg::PH_NEED_BYTE;
			emit(i2crts_pkg::ACT_REQ, 8'h00, 1'b0, i2crts_pkg::ST_OK);
		end else begin
			close_out(i2crts_pkg::ST_OK);
		end
	endfunction

	// clean master done: move on through address, register and data bytes
	function automatic void advance_on_done();
		fail_code = i2crts_pkg::ST_NOACK;
		case (seq_phase)
			i2crts_pkg::PH_MB_ADDR: begin
				if (hold_nreg >= i2crts_pkg::REG_MAX) begin
					emit(i2crts_pkg::ACT_SEND, hold_addr[15:8], 1'b0, i2crts_pkg::ST_OK);
					open_wait(i2crts_pkg::PH_MB_REGHI);
				end else if (hold_nreg == 2'd1) begin
					emit(i2crts_pkg::ACT_SEND, hold_addr[7:0], 1'b0, i2crts_pkg::ST_OK);
					open_wait(i2crts_pkg::PH_MB_REGLO);
				end else begin
					data_or_stop();
				end
			end
			i2crts_pkg::PH_MB_REGHI: begin
				emit(i2crts_pkg::ACT_SEND, hold_addr[7:0], 1'b0, i2crts_pkg::ST_OK);
				open_wait(i2crts_pkg::PH_MB_REGLO);
			end
			i2crts_pkg::PH_MB_REGLO: begin
				if (hold_read)
					issue_read_address();
				else
					data_or_stop();
			end
			default: data_or_stop();
		endcase
	endfunction

	// predict the actions of one accepted transfer and queue them
	function automatic void compute_actions(i2crts_pkg::item_t it);
		i2crts_pkg::result_t r;
		int k;
		step_n = 0;
		case (it.op)
			i2crts_pkg::OP_START: begin
				if (seq_phase == i2crts_pkg::PH_IDLE) begin
					hold_read  = it.is_read;
					hold_dev   = it.device_byte;
					hold_nreg  = (it.reg_bytes > i2crts_pkg::REG_MAX) ? i2crts_pkg::REG_MAX
					                                                  : it.reg_bytes;
					hold_addr  = it.reg_addr;
					bytes_left = it.length;
					if (hold_read && bytes_left == 16'd0) begin
						emit(i2crts_pkg::ACT_FINISH, 8'h00, 1'b0, i2crts_pkg::ST_BADLEN);
					end else if (hold_read && hold_nreg == 2'd0) begin
						issue_read_address();
					end else begin
						emit(i2crts_pkg::ACT_ADDR, hold_dev, 1'b0, i2crts_pkg::ST_OK);
						fail_code = i2crts_pkg::ST_NODEV;
						open_wait(i2crts_pkg::PH_MB_ADDR);
					end
				end
			end
			i2crts_pkg::OP_WRBYTE: begin
				if (seq_phase == i2crts_pkg::PH_NEED_BYTE) begin
					emit(i2crts_pkg::ACT_SEND, it.write_byte, 1'b0, i2crts_pkg::ST_OK);
					bytes_left = bytes_left - 16'd1;
					open_wait(i2crts_pkg::PH_MB_DATA);
				end
			end
			i2crts_pkg::OP_MDONE: begin
				if (seq_phase == i2crts_pkg::PH_MB_ADDR ||
				    seq_phase == i2crts_pkg::PH_MB_REGHI ||
				    seq_phase == i2crts_pkg::PH_MB_REGLO ||
				    seq_phase == i2crts_pkg::PH_MB_DATA) begin
					if (it.bus_fault)
						close_out(i2crts_pkg::ST_BUSERR);
					else if (it.rx_nack)
						close_out(fail_code);
					else if (it.arb_lost)
						close_out(i2crts_pkg::ST_BUSERR);
					else
						advance_on_done();
				end
			end
			i2crts_pkg::OP_SBYTE: begin
				if (seq_phase == i2crts_pkg::PH_SB_WAIT) begin
					if (it.rx_nack) begin
						close_out(i2crts_pkg::ST_NOACK);
					end else if (it.arb_lost) begin
						close_out(i2crts_pkg::ST_BUSERR);
					end else begin
						emit(i2crts_pkg::ACT_DELIVER, it.rx_byte, 1'b0, i2crts_pkg::ST_OK);
						bytes_left = bytes_left - 16'd1;
						if (bytes_left == 16'd0) begin
							close_out(i2crts_pkg::ST_OK);
						end else begin
							emit(i2crts_pkg::ACT_READNEXT, 8'h00, bytes_left == 16'd1,
								i2crts_pkg::ST_OK);
							open_wait(i2crts_pkg::PH_SB_WAIT);
						end
					end
				end
			end
			i2crts_pkg::OP_TICK: begin
				if (seq_phase != i2crts_pkg::PH_IDLE &&
				    seq_phase != i2crts_pkg::PH_NEED_BYTE) begin
					wait_left = wait_left - 16'd1;
					if (wait_left == 16'd0)
						close_out(i2crts_pkg::ST_BUSERR);
				end
			end
			default: ;
		endcase
		for (k = 0; k < step_n; k++) begin
			r = step_res[k];
			r.last = (k == step_n - 1);
			action_queue.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// compare each output transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		i2crts_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (action_queue.size() == 0) begin
				$error("unexpected result: action %0d byte %0h", action, byte_value);
				errors++;
			end else begin
				want = action_queue.pop_front();
				check_field("action", 8'(want.action), 8'(action));
				check_field("byte_value", want.byte_value, byte_value);
				check_field("nack_next", 8'(want.nack_next), 8'(nack_next));
				check_field("status", 8'(want.status), 8'(status));
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	// receiver: long hold-off on request, otherwise a changing stall pattern
	always @(negedge clk) begin
		if (holdoff_request != 0) begin
			hold_left = holdoff_request;
			holdoff_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (rx_run == 0) begin
				rx_run = $urandom_range(4, 48);
				rx_mode = $urandom_range(0, 3);
			end
			rx_run--;
			rx_tick++;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= (rx_tick % 3 == 0);
				default: out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic i2crts_pkg::item_t random_fields();
		i2crts_pkg::item_t it;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		a = $urandom;
		b = $urandom;
		c = $urandom;
		it.op          = a[2:0];
		it.is_read     = a[3];
		it.device_byte = (a[11:4] == 8'hFF) ? 8'hFE : a[11:4];
		it.reg_bytes   = a[13:12];
		it.write_byte  = a[21:14];
		it.rx_nack     = a[22];
		it.arb_lost    = a[23];
		it.bus_fault   = a[24];
		it.reg_addr    = b[15:0];
		it.length      = b[31:16];
		it.rx_byte     = c[7:0];
		return it;
	endfunction

	// mostly short transfers, a few of the longest
	function automatic logic [15:0] pick_length();
		int r;
		logic [31:0] w;
		r = $urandom_range(0, 99);
		w = $urandom;
		if (r < 8)
			return 16'd0;
		if (r < 70)
			return {14'd0, w[1:0]} + 16'd1;
		if (r < 92)
			return {12'd0, w[3:0]} + 16'd5;
		if (r < 96)
			return 16'hFFFF;
		return w[15:0];
	endfunction

	// sender bursts with random gaps between them
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// offer one item and hold it until the transfer
	task automatic send_item(i2crts_pkg::item_t it);
		@(negedge clk);
		in_valid    <= 1'b1;
		op          <= it.op;
		is_read     <= it.is_read;
		device_byte <= it.device_byte;
		reg_bytes   <= it.reg_bytes;
		reg_addr    <= it.reg_addr;
		length      <= it.length;
		write_byte  <= it.write_byte;
		rx_nack     <= it.rx_nack;
		arb_lost    <= it.arb_lost;
		bus_fault   <= it.bus_fault;
		rx_byte     <= it.rx_byte;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		compute_actions(it);
		pace();
	endtask

	task automatic do_start(logic rd, logic [7:0] dev, logic [1:0] nreg,
	                        logic [15:0] addr, logic [15:0] len);
		i2crts_pkg::item_t it;
		it = random_fields();
		it.op          = i2crts_pkg::OP_START;
		it.is_read     = rd;
		it.device_byte = dev;
		it.reg_bytes   = nreg;
		it.reg_addr    = addr;
		it.length      = len;
		send_item(it);
	endtask

	task automatic do_event(logic [2:0] code, logic nack, logic arb, logic fault,
	                        logic [7:0] data);
		i2crts_pkg::item_t it;
		it = random_fields();
		it.op         = code;
		it.rx_nack    = nack;
		it.arb_lost   = arb;
		it.bus_fault  = fault;
		it.rx_byte    = data;
		it.write_byte = data;
		send_item(it);
	endtask

	// next item chosen from the predicted phase, with some stray items
	task automatic pick_next(output i2crts_pkg::item_t it, output bit useful);
		int roll;
		bit abort;
		it = random_fields();
		useful = 1'b1;
		roll = $urandom_range(0, 99);
		if (bytes_left > 16'd12)
			abort = ($urandom_range(0, 3) == 0);
		else
			abort = ($urandom_range(0, 19) == 0);
		if (roll < 7) begin
			useful = 1'b0;
		end else if (seq_phase == i2crts_pkg::PH_IDLE) begin
			it.op = i2crts_pkg::OP_START;
			it.length = pick_length();
		end else if (seq_phase == i2crts_pkg::PH_NEED_BYTE) begin
			it.op = i2crts_pkg::OP_WRBYTE;
		end else if (roll < 17) begin
			it.op = i2crts_pkg::OP_TICK;
		end else begin
			it.op = (seq_phase == i2crts_pkg::PH_SB_WAIT) ? i2crts_pkg::OP_SBYTE
			                                              : i2crts_pkg::OP_MDONE;
			if (!abort) begin
				it.rx_nack  = 1'b0;
				it.arb_lost = 1'b0;
				if (seq_phase != i2crts_pkg::PH_SB_WAIT)
					it.bus_fault = 1'b0;
			end
		end
	endtask

	// drop valid, wait for all results, then let the pipeline empty
	task automatic settle();
		int spent;
		spent = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (action_queue.size() != 0 && spent < 200000) begin
			@(posedge clk);
			spent++;
		end
		if (action_queue.size() != 0) begin
			$error("results still outstanding: %0d", action_queue.size());
			errors++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_wait_limit(logic [15:0] value);
		@(negedge clk);
		wait_limit_we    <= 1'b1;
		wait_limit_wdata <= value;
		@(posedge clk);
		limit_mirror = value;
		@(negedge clk);
		wait_limit_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_write_sequence();
		// three register bytes act as two, high byte first
		do_start(1'b0, 8'hFE, i2crts_pkg::REG_ALL, 16'hA55A, 16'd1);
		do_event(i2crts_pkg::OP_MDONE, 1'b0, 1'b0, 1'b0, 8'h00);
		// a start while busy is dropped
		do_start(1'b1, 8'h10, 2'd0, 16'h0000, 16'd0);
		do_event(i2crts_pkg::OP_MDONE, 1'b0, 1'b0, 1'b0, 8'h00);
		do_event(i2crts_pkg::OP_MDONE, 1'b0, 1'b0, 1'b0, 8'h00);
		// ticks do not count while write data is awaited
		do_event(i2crts_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 8'h00);
		do_event(i2crts_pkg::OP_WRBYTE, 1'b0, 1'b0, 1'b0, 8'hFF);
		do_event(OP_UNUSED, 1'b0, 1'b0, 1'b0, 8'h00);
		do_event(i2crts_pkg::OP_MDONE, 1'b0, 1'b0, 1'b0, 8'h00);
		settle();
	endtask

	task automatic test_read_sequence();
		// odd device byte, no register phase
		do_start(1'b1, 8'h55, 2'd0, 16'h0000, 16'd2);
		// bus fault flag is ignored on a slave byte
		do_event(i2crts_pkg::OP_SBYTE, 1'b0, 1'b0, 1'b1, 8'h00);
		do_event(i2crts_pkg::OP_MDONE, 1'b0, 1'b0, 1'b0, 8'h00);
		do_event(i2crts_pkg::OP_SBYTE, 1'b0, 1'b0, 1'b0, 8'hFF);
		// zero-length read fails at once
		do_start(1'b1, 8'h00, 2'd0, 16'hFFFF, 16'd0);
		// register phase, then read address, then nack from the device
		do_start(1'b1, 8'h00, 2'd1, 16'h00FF, 16'hFFFF);
		do_event(i2crts_pkg::OP_MDONE, 1'b0, 1'b0, 1'b0, 8'h00);
		do_event(i2crts_pkg::OP_MDONE, 1'b0, 1'b0, 1'b0, 8'h00);
		do_event(i2crts_pkg::OP_SBYTE, 1'b1, 1'b0, 1'b0, 8'h5A);
		settle();
	endtask

	task automatic test_event_failures();
		// nack on the first address: no device
		do_start(1'b0, 8'h42, 2'd0, 16'h0000, 16'd0);
		do_event(i2crts_pkg::OP_MDONE, 1'b1, 1'b0, 1'b0, 8'h00);
		// nack on a register byte: no ack
		do_start(1'b0, 8'h42, 2'd2, 16'hBEEF, 16'd3);
		do_event(i2crts_pkg::OP_MDONE, 1'b0, 1'b0, 1'b0, 8'h00);
		do_event(i2crts_pkg::OP_MDONE, 1'b1, 1'b0, 1'b0, 8'h00);
		// lost arbitration
		do_start(1'b0, 8'h80, 2'd1, 16'h1234, 16'd1);
		do_event(i2crts_pkg::OP_MDONE, 1'b0, 1'b1, 1'b0, 8'h00);
		// bus fault wins over nack
		do_start(1'b0, 8'h7E, 2'd0, 16'h0000, 16'd1);
		do_event(i2crts_pkg::OP_MDONE, 1'b1, 1'b1, 1'b1, 8'h00);
		// lost arbitration while reading
		do_start(1'b1, 8'hA0, 2'd0, 16'h0000, 16'd1);
		do_event(i2crts_pkg::OP_SBYTE, 1'b0, 1'b1, 1'b0, 8'h33);
		settle();
	endtask

	task automatic test_wait_timeout();
		set_wait_limit(16'd2);
		do_start(1'b0, 8'h20, 2'd0, 16'h0000, 16'd1);
		do_event(i2crts_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 8'h00);
		do_event(i2crts_pkg::OP_MDONE, 1'b0, 1'b0, 1'b0, 8'h00);
		do_event(i2crts_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 8'h00);
		// wait count reloads here
		do_event(i2crts_pkg::OP_WRBYTE, 1'b0, 1'b0, 1'b0, 8'h00);
		do_event(i2crts_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 8'h00);
		do_event(i2crts_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 8'h00);
		settle();
	endtask

	// output held off while transfers keep coming in
	task automatic test_backpressure();
		i2crts_pkg::item_t it;
		bit useful;
		int n;
		set_wait_limit(i2crts_pkg::WAIT_RESET);
		holdoff_request = 400;
		do_start(1'b0, 8'h3C, 2'd2, 16'h1234, 16'd12);
		for (n = 0; n < 40; n++) begin
			pick_next(it, useful);
			send_item(it);
		end
		settle();
	endtask

	task automatic test_random_traffic(logic [15:0] limit_value, int useful_items);
		i2crts_pkg::item_t it;
		bit useful;
		int done_items;
		set_wait_limit(limit_value);
		done_items = 0;
		while (done_items < useful_items) begin
			pick_next(it, useful);
			send_item(it);
			if (useful)
				done_items++;
		end
		settle();
	endtask

	// ------------------------------------------------------------------
	// run
	// ------------------------------------------------------------------
	initial begin
		logic [31:0] w;
		arst_n           = 1'b0;
		wait_limit_we    = 1'b0;
		wait_limit_wdata = 16'd0;
		in_valid         = 1'b0;
		op               = i2crts_pkg::OP_TICK;
		is_read          = 1'b0;
		device_byte      = 8'd0;
		reg_bytes        = 2'd0;
		reg_addr         = 16'd0;
		length           = 16'd0;
		write_byte       = 8'd0;
		rx_nack          = 1'b0;
		arb_lost         = 1'b0;
		bus_fault        = 1'b0;
		rx_byte          = 8'd0;
		clear_mirror();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_write_sequence();
		test_read_sequence();
		test_event_failures();
		test_wait_timeout();
		test_backpressure();
		test_random_traffic(i2crts_pkg::WAIT_RESET, 45);
		test_random_traffic(16'd1, 35);
		test_random_traffic(16'hFFFF, 45);
		w = $urandom_range(2, 12);
		test_random_traffic(w[15:0], 50);
		w = $urandom_range(1, 65535);
		test_random_traffic(w[15:0], 60);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog
	initial begin
		#(RUN_LIMIT);
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/i2crts_pkg.sv
sv/i2crts_step.sv
sv/i2crts_outbuf.sv
sv/i2c_register_transaction_sequencer.sv
dv/tb_i2c_register_transaction_sequencer.sv
